@@ hdl/alsh_pkg.sv @@
package alsh_pkg;

    localparam int MAX_DIM     = 256;
    localparam int MAX_EXT     = 4;
    localparam int STORE_DEPTH = MAX_DIM + 2 * MAX_EXT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_DIM + 1);
    localparam int EXT_W       = $clog2(MAX_EXT + 1);

    localparam logic [2:0] CFG_HASH_MODE  = 3'd0;
    localparam logic [2:0] CFG_EXT_MODE   = 3'd1;
    localparam logic [2:0] CFG_EXT_TERMS  = 3'd2;
    localparam logic [2:0] CFG_OFFSET     = 3'd3;
    localparam logic [2:0] CFG_INV_WIDTH  = 3'd4;

    localparam logic [2:0] EXT_NONE       = 3'd0;
    localparam logic [2:0] EXT_INDEX_L2   = 3'd1;
    localparam logic [2:0] EXT_QUERY_L2   = 3'd2;
    localparam logic [2:0] EXT_INDEX_COS  = 3'd3;
    localparam logic [2:0] EXT_QUERY_COS  = 3'd4;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ELEMENT = 1'b1;

    typedef struct packed {
        logic               op;
        logic [8:0]         entry_index;
        logic signed [31:0] element_value;
        logic               last_element;
    } in_t;

    typedef struct packed {
        logic signed [31:0] hash_value;
        logic               saturated;
        logic               too_long;
    } out_t;

    // {overflow, saturated sum}
    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        logic        ovf;
        s   = a + b;
        ovf = (a[63] == b[63]) && (s[63] != a[63]);
        if (ovf)
        begin
            s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return {ovf, s};
    endfunction

endpackage

@@ hdl/alsh_ram.sv @@
module alsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 264
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/alsh_projection_hash_top.sv @@
// Load beat: a store write. Element beat: store read, dot MAC, square MAC,
// through one shared 33x33 multiplier. A last element adds m extension terms
// (m = clamped term count, none if mode off) and a finish: sign, or L2 (offset add,
// two 32-bit partial products, sum).
// Reset (rst_n, async low) clears accumulators, counters, flags and config;
// the projection store is not cleared.
module alsh_projection_hash_top
    import alsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_DOT   = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_XINIT = 4'd4;
    localparam logic [3:0] S_XA    = 4'd5;
    localparam logic [3:0] S_XB    = 4'd6;
    localparam logic [3:0] S_XC    = 4'd7;
    localparam logic [3:0] S_XD    = 4'd8;
    localparam logic [3:0] S_HASH  = 4'd9;
    localparam logic [3:0] S_HLO   = 4'd10;
    localparam logic [3:0] S_HHI   = 4'd11;
    localparam logic [3:0] S_HSUM  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    localparam logic signed [32:0] Q_HALF = 33'sd1 << 26;

    logic [3:0]         state_reg, state_next;
    logic               hash_mode_reg;
    logic [2:0]         ext_mode_reg;
    logic [2:0]         ext_terms_reg;
    logic [31:0]        offset_reg;
    logic [31:0]        inv_width_reg;

    logic [63:0]        dot_reg, dot_next;
    logic [63:0]        sq_reg, sq_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               long_reg, long_next;
    logic signed [31:0] x_reg, x_next;
    logic               last_reg, last_next;
    logic [63:0]        prod_reg, prod_next;
    logic [30:0]        p_reg, p_next;
    logic [30:0]        s_reg, s_next;
    logic [EXT_W-1:0]   i_reg, i_next;
    logic [EXT_W-1:0]   m_reg, m_next;
    logic [63:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [31:0]        lohi_reg, lohi_next;
    logic [31:0]        hash_reg, hash_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [31:0]        ram_rdata;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [32:0] term_first, term_second, half_minus_p;
    logic [64:0]        dot_add;
    logic [63:0]        dot_addend;
    logic [64:0]        sq_add;
    logic               accept;
    logic [63:0]        mid;
    logic [25:0]        q;
    logic [36:0]        s_wide;
    logic [ADDR_W-1:0]  base_addr;

    alsh_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_data.element_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign ram_waddr = in_data.entry_index[ADDR_W-1:0];
    assign ram_we    = accept && (in_data.op == OP_LOAD)
                       && (32'(in_data.entry_index) < 32'(STORE_DEPTH));

    assign half_minus_p = Q_HALF - $signed({2'b00, p_reg});
    assign base_addr    = ADDR_W'(count_reg);

    always_comb
    begin
        term_first  = '0;
        term_second = '0;
        case (ext_mode_reg)
            EXT_INDEX_L2:
            begin
                term_first  = $signed({2'b00, p_reg});
                term_second = Q_HALF;
            end
            EXT_QUERY_L2:
            begin
                term_first  = Q_HALF;
                term_second = $signed({2'b00, p_reg});
            end
            EXT_INDEX_COS: term_first  = half_minus_p;
            EXT_QUERY_COS: term_second = half_minus_p;
            default:
            begin
                term_first  = '0;
                term_second = '0;
            end
        endcase
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RD:
            begin
                mul_a = 33'(x_reg);
                mul_b = 33'($signed(ram_rdata));
            end
            S_DOT:
            begin
                mul_a = 33'(x_reg);
                mul_b = 33'(x_reg);
            end
            S_XA:
            begin
                mul_a = term_first;
                mul_b = 33'($signed(ram_rdata));
            end
            S_XB:
            begin
                mul_a = term_second;
                mul_b = 33'($signed(ram_rdata));
            end
            S_XC:
            begin
                mul_a = $signed({2'b00, p_reg});
                mul_b = $signed({2'b00, s_reg});
            end
            S_HLO:
            begin
                mul_a = $signed({1'b0, mag_reg[31:0]});
                mul_b = $signed({1'b0, inv_width_reg});
            end
            S_HHI:
            begin
                mul_a = $signed({1'b0, mag_reg[63:32]});
                mul_b = $signed({1'b0, inv_width_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        dot_addend = prod_reg;
        if (state_reg == S_HASH)
        begin
            dot_addend = {{5{offset_reg[31]}}, offset_reg, 27'b0};
        end
    end

    assign dot_add = sat_add(dot_reg, dot_addend);
    assign sq_add  = sat_add(sq_reg, prod_reg);
    assign s_wide  = sq_reg[63:27];
    assign mid     = prod_reg + {32'b0, lohi_reg};
    assign q       = mid[63:38];

    always_comb
    begin
        state_next     = state_reg;
        dot_next       = dot_reg;
        sq_next        = sq_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        long_next      = long_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        i_next         = i_reg;
        m_next         = m_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        lohi_next      = lohi_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_raddr      = base_addr;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.op == OP_ELEMENT)
                begin
                    x_next    = in_data.element_value;
                    last_next = in_data.last_element;
                    if (32'(count_reg) < 32'(MAX_DIM))
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        long_next = 1'b1;
                        if (in_data.last_element)
                        begin
                            state_next = S_XINIT;
                        end
                    end
                end
            end
            S_RD:
            begin
                prod_next  = mul_p[63:0];
                state_next = S_DOT;
            end
            S_DOT:
            begin
                dot_next   = dot_add[63:0];
                ovf_next   = ovf_reg | dot_add[64];
                prod_next  = mul_p[63:0];
                state_next = S_SQ;
            end
            S_SQ:
            begin
                sq_next    = sq_add[63:0];
                ovf_next   = ovf_reg | sq_add[64];
                count_next = count_reg + CNT_W'(1);
                state_next = last_reg ? S_XINIT : S_IDLE;
            end
            S_XINIT:
            begin
                m_next = (32'(ext_terms_reg) > 32'(MAX_EXT)) ? EXT_W'(MAX_EXT)
                                                             : EXT_W'(ext_terms_reg);
                i_next = '0;
                if (!(ext_mode_reg inside {[EXT_INDEX_L2:EXT_QUERY_COS]}))
                begin
                    state_next = S_HASH;
                end
                else
                begin
                    // norm clamp flags even when no terms follow
                    if (s_wide[36:31] != '0)
                    begin
                        s_next   = '1;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        s_next = s_wide[30:0];
                    end
                    p_next     = s_next;
                    state_next = (m_next == '0) ? S_HASH : S_XA;
                end
            end
            S_XA:
            begin
                prod_next  = mul_p[63:0];
                ram_raddr  = base_addr + ADDR_W'(m_reg) + ADDR_W'(i_reg);
                state_next = S_XB;
            end
            S_XB:
            begin
                dot_next   = dot_add[63:0];
                ovf_next   = ovf_reg | dot_add[64];
                prod_next  = mul_p[63:0];
                state_next = S_XC;
            end
            S_XC:
            begin
                dot_next   = dot_add[63:0];
                ovf_next   = ovf_reg | dot_add[64];
                prod_next  = mul_p[63:0];
                state_next = S_XD;
            end
            S_XD:
            begin
                // next power, truncated then clamped
                if (prod_reg[61:58] != '0)
                begin
                    p_next = '1;
                    if (i_reg + EXT_W'(1) < m_reg)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    p_next = prod_reg[57:27];
                end
                i_next    = i_reg + EXT_W'(1);
                ram_raddr = base_addr + ADDR_W'(i_next);
                state_next = (i_next < m_reg) ? S_XA : S_HASH;
            end
            S_HASH:
            begin
                if (hash_mode_reg)
                begin
                    hash_next  = {31'b0, (!dot_reg[63] && dot_reg != '0)};
                    state_next = S_DONE;
                end
                else
                begin
                    ovf_next   = ovf_reg | dot_add[64];
                    neg_next   = dot_add[63];
                    mag_next   = dot_add[63] ? (64'd0 - dot_add[63:0]) : dot_add[63:0];
                    state_next = S_HLO;
                end
            end
            S_HLO:
            begin
                prod_next  = mul_p[63:0];
                state_next = S_HHI;
            end
            S_HHI:
            begin
                lohi_next  = prod_reg[63:32];
                prod_next  = mul_p[63:0];
                state_next = S_HSUM;
            end
            S_HSUM:
            begin
                hash_next  = neg_reg ? (32'd0 - {6'b0, q}) : {6'b0, q};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.hash_value  = hash_reg;
                    out_next.saturated   = ovf_reg;
                    out_next.too_long    = long_reg;
                    dot_next             = '0;
                    sq_next              = '0;
                    count_next           = '0;
                    ovf_next             = 1'b0;
                    long_next            = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hash_mode_reg <= 1'b0;
            ext_mode_reg  <= EXT_NONE;
            ext_terms_reg <= '0;
            offset_reg    <= '0;
            inv_width_reg <= 32'h0001_0000;
            dot_reg       <= '0;
            sq_reg        <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            long_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            m_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dot_reg       <= dot_next;
            sq_reg        <= sq_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            long_reg      <= long_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            m_reg         <= m_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_HASH_MODE: hash_mode_reg <= cfg_data[0];
                    CFG_EXT_MODE:  ext_mode_reg  <= cfg_data[2:0];
                    CFG_EXT_TERMS: ext_terms_reg <= cfg_data[2:0];
                    CFG_OFFSET:    offset_reg    <= cfg_data;
                    CFG_INV_WIDTH: inv_width_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        last_reg <= last_next;
        prod_reg <= prod_next;
        p_reg    <= p_next;
        s_reg    <= s_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        lohi_reg <= lohi_next;
        hash_reg <= hash_next;
        out_reg  <= out_next;
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import alsh_pkg::*;

    localparam int  CYCLE_LIMIT = 600000;
    localparam int  SETTLE      = 40;
    localparam int  HOLD_LEN    = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = CFG_HASH_MODE;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_data;

    alsh_projection_hash_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the block
    logic signed [31:0] proj_img [STORE_DEPTH];
    longint             dot_sum;
    longint             norm_sum;
    int unsigned        elem_seen;
    bit                 sat_seen;
    bit                 long_seen;
    bit                 sign_mode;
    logic [2:0]         ext_sel;
    logic [2:0]         ext_count;
    logic signed [31:0] bias;
    logic [31:0]        inv_width;

    in_t  beat_queue [$];
    out_t hash_queue [$];

    int   errors = 0;
    int   hashes_seen = 0;
    int   beats_sent = 0;
    int   cycle = 0;
    bit   calm = 1'b0;
    bit   tx_hold = 1'b0;
    bit   rx_hold_req = 1'b0;
    bit   rx_hold_done = 1'b0;
    int   rx_hold_left = 0;
    bit   sat_hits = 0;
    bit   long_hits = 0;

    function automatic longint clamp_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            sat_seen = 1'b1;
            s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

    function automatic longint entry(int unsigned idx);
        return longint'(proj_img[idx]);
    endfunction

    function automatic void append_extension();
        int unsigned m;
        int unsigned i;
        logic [63:0] nrm;
        logic [63:0] pw;
        longint      first;
        longint      second;
        longint      half;
        m = (ext_count > MAX_EXT) ? MAX_EXT : ext_count;
        half = 64'sd1 <<< 26;
        if (ext_sel < EXT_INDEX_L2 || ext_sel > EXT_QUERY_COS)
            return;
        nrm = 64'(norm_sum) >> 27;
        if (nrm > 64'h7FFF_FFFF)
        begin
            nrm = 64'h7FFF_FFFF;
            sat_seen = 1'b1;
        end
        pw = nrm;
        for (i = 0; i < m; i++)
        begin
            case (ext_sel)
                EXT_INDEX_L2:
                begin
                    first = longint'(pw);
                    second = half;
                end
                EXT_QUERY_L2:
                begin
                    first = half;
                    second = longint'(pw);
                end
                EXT_INDEX_COS:
                begin
                    first = half - longint'(pw);
                    second = 0;
                end
                default:
                begin
                    first = 0;
                    second = half - longint'(pw);
                end
            endcase
            dot_sum = clamp_sum(dot_sum, first * entry(elem_seen + i));
            dot_sum = clamp_sum(dot_sum, second * entry(elem_seen + m + i));
            pw = (pw * nrm) >> 27;
            if (pw > 64'h7FFF_FFFF)
            begin
                pw = 64'h7FFF_FFFF;
                if (i + 1 < m)
                    sat_seen = 1'b1;
            end
        end
    endfunction

    function automatic logic [31:0] bucket_of();
        longint      v;
        bit          neg;
        logic [95:0] prod;
        logic [31:0] q;
        v = clamp_sum(dot_sum, longint'(bias) * 64'sd134217728);
        neg = v < 0;
        prod = {32'b0, (neg ? 64'd0 - 64'(v) : 64'(v))} * {64'b0, inv_width};
        q = {6'b0, prod[95:70]};
        return neg ? 32'd0 - q : q;
    endfunction

    function automatic void predict_beat(in_t b);
        out_t r;
        if (b.op == OP_LOAD)
        begin
            if (b.entry_index < STORE_DEPTH)
                proj_img[b.entry_index] = b.element_value;
            return;
        end
        if (elem_seen < MAX_DIM)
        begin
            dot_sum = clamp_sum(dot_sum, longint'(b.element_value) * entry(elem_seen));
            norm_sum = clamp_sum(norm_sum,
                                 longint'(b.element_value) * longint'(b.element_value));
            elem_seen++;
        end
        else
            long_seen = 1'b1;
        if (!b.last_element)
            return;
        append_extension();
        r.hash_value = sign_mode ? ((dot_sum > 0) ? 32'sd1 : 32'sd0) : bucket_of();
        r.saturated = sat_seen;
        r.too_long = long_seen;
        if (sat_seen) sat_hits = 1;
        if (long_seen) long_hits = 1;
        hash_queue.push_back(r);
        dot_sum = 0;
        norm_sum = 0;
        elem_seen = 0;
        sat_seen = 1'b0;
        long_seen = 1'b0;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("[%0d] mismatch %s: got %0h expected %0h", cycle, what, got, want);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            predict_beat(in_data);
            void'(beat_queue.pop_front());
            beats_sent++;
        end
        if (!in_valid || in_ready)
        begin
            if (beat_queue.size() > 0 && !tx_hold && (calm || $urandom_range(99) >= 31))
            begin
                in_valid <= 1'b1;
                in_data <= beat_queue[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_req && !rx_hold_done)
        begin
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_LEN;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 31);
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (hash_queue.size() == 0)
            begin
                errors++;
                $display("[%0d] hash beat with nothing expected", cycle);
            end
            else
            begin
                if (out_data.hash_value !== hash_queue[0].hash_value)
                    report("hash_value", out_data.hash_value, hash_queue[0].hash_value);
                if (out_data.saturated !== hash_queue[0].saturated)
                    report("saturated", out_data.saturated, hash_queue[0].saturated);
                if (out_data.too_long !== hash_queue[0].too_long)
                    report("too_long", out_data.too_long, hash_queue[0].too_long);
                void'(hash_queue.pop_front());
                hashes_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_beat(logic op, logic [8:0] idx, logic [31:0] val, logic last);
        in_t b;
        b.op = op;
        b.entry_index = idx;
        b.element_value = val;
        b.last_element = last;
        beat_queue.push_back(b);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom_range(32'h1000_0000) - 32'h0800_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_vector(int unsigned len);
        int unsigned k;
        for (k = 0; k < len; k++)
            push_beat(OP_ELEMENT, 9'($urandom), pick_value(), k == len - 1);
    endtask

    task automatic drain();
        wait (beat_queue.size() == 0 && !in_valid && hash_queue.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_HASH_MODE: sign_mode = val[0];
            CFG_EXT_MODE:  ext_sel = val[2:0];
            CFG_EXT_TERMS: ext_count = val[2:0];
            CFG_OFFSET:    bias = val;
            default:       inv_width = val;
        endcase
    endtask

    task automatic setup(logic hm, logic [2:0] em, logic [2:0] et, logic [31:0] off,
                         logic [31:0] iw);
        write_reg(CFG_HASH_MODE, {31'b0, hm});
        write_reg(CFG_EXT_MODE, {29'b0, em});
        write_reg(CFG_EXT_TERMS, {29'b0, et});
        write_reg(CFG_OFFSET, off);
        write_reg(CFG_INV_WIDTH, iw);
    endtask

    initial
    begin
        int unsigned i;
        int unsigned ph;
        int unsigned target;
        dot_sum = 0;
        norm_sum = 0;
        elem_seen = 0;
        sat_seen = 0;
        long_seen = 0;
        sign_mode = 0;
        ext_sel = EXT_NONE;
        ext_count = 0;
        bias = 0;
        inv_width = 32'h0001_0000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole projection store so no entry is read unwritten
        for (i = 0; i < STORE_DEPTH; i++)
            push_beat(OP_LOAD, 9'(i), pick_value(), 1'b0);

        // directed: reset config, extremes, ignored loads, saturation
        push_vector(1);
        push_beat(OP_ELEMENT, 9'd0, 32'h7FFF_FFFF, 1'b0);
        push_beat(OP_ELEMENT, 9'd0, 32'h8000_0000, 1'b1);
        push_beat(OP_LOAD, 9'd264, 32'h1234_5678, 1'b0);
        push_beat(OP_LOAD, 9'd511, 32'hFFFF_FFFF, 1'b0);
        push_beat(OP_LOAD, 9'd3, 32'h8000_0000, 1'b1);
        for (i = 0; i < 3; i++)
            push_beat(OP_LOAD, 9'(i), 32'h8000_0000, 1'b0);
        for (i = 0; i < 3; i++)
            push_beat(OP_ELEMENT, 9'h1FF, 32'h8000_0000, i == 2);
        drain();

        setup(1'b0, EXT_INDEX_L2, 3'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        for (i = 0; i < 3; i++)
            push_beat(OP_ELEMENT, 9'd0, 32'h7FFF_FFFF, i == 2);
        push_vector(2);
        drain();
        setup(1'b1, EXT_QUERY_COS, 3'd4, 32'h8000_0000, 32'h0);
        push_vector(3);
        push_beat(OP_ELEMENT, 9'd0, 32'h8000_0000, 1'b1);
        drain();

        // random phases with a fresh setting each
        target = 850;
        for (ph = 0; ph < 4 || beats_sent + beat_queue.size() < target; ph++)
        begin
            case (ph % 6)
                0: setup(1'b0, EXT_NONE, 3'd0, 32'h0, 32'h0001_0000);
                1: setup(1'b0, EXT_QUERY_L2, 3'($urandom_range(7)), $urandom, $urandom);
                2: setup(1'b1, EXT_INDEX_COS, 3'($urandom_range(7)), $urandom, $urandom);
                3: setup(1'b0, 3'($urandom_range(7)), 3'($urandom_range(7)),
                         32'h8000_0000, 32'h0);
                4: setup(1'($urandom), EXT_QUERY_COS, 3'd1, $urandom, 32'hFFFF_FFFF);
                default: setup(1'b0, EXT_INDEX_L2, 3'd4, $urandom, $urandom_range(1 << 20));
            endcase
            calm = (ph == 2);
            if (ph == 1)
                rx_hold_req = 1'b1;
            for (i = 0; i < 12; i++)
            begin
                if ($urandom_range(99) < 15)
                    push_beat(OP_LOAD, 9'($urandom), pick_value(), 1'($urandom));
                else if ($urandom_range(99) < 3 && ph % 3 == 0)
                    push_vector($urandom_range(258, 255));
                else if ($urandom_range(99) < 90)
                    push_vector($urandom_range(8, 1));
                else
                    push_vector($urandom_range(40, 9));
            end
            // in phase 3 the sender is held until no hash is outstanding
            tx_hold = (ph == 3);
            wait (hash_queue.size() == 0 || !tx_hold);
            tx_hold = 1'b0;
            drain();
        end
        calm = 1'b0;

        $display("%0d beats sent, %0d hashes checked over %0d phases", beats_sent,
                 hashes_seen, ph);
        $display("saturation seen: %0d, over-length vector seen: %0d", sat_hits, long_hits);
        if (errors == 0 && hash_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
